FILE: design/sbmc_pkg.sv
// Shared types and constants for the SQL bind marker counter.
// Byte class codes, queue item layout and configuration bundle.
// No dependencies.
package sbmc_pkg;

   localparam int COUNT_BITS  = 16;
   localparam int RESULT_BITS = 16;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // byte classes handed from the front end to the scanner
   localparam int CLS_BITS = 4;
   localparam logic [CLS_BITS-1:0] CLS_OTHER   = 4'd0;
   localparam logic [CLS_BITS-1:0] CLS_ZERO    = 4'd1;
   localparam logic [CLS_BITS-1:0] CLS_QMARK   = 4'd2;
   localparam logic [CLS_BITS-1:0] CLS_DASH    = 4'd3;
   localparam logic [CLS_BITS-1:0] CLS_SLASH   = 4'd4;
   localparam logic [CLS_BITS-1:0] CLS_STAR    = 4'd5;
   localparam logic [CLS_BITS-1:0] CLS_NEWLINE = 4'd6;
   localparam logic [CLS_BITS-1:0] CLS_SQUOTE  = 4'd7;
   localparam logic [CLS_BITS-1:0] CLS_DQUOTE  = 4'd8;
   localparam logic [CLS_BITS-1:0] CLS_BSLASH  = 4'd9;

   // configuration register indexes
   localparam logic CSR_ANSI_QUOTES   = 1'b0;
   localparam logic CSR_NO_BS_ESCAPES = 1'b1;

   typedef struct packed {
      logic [CLS_BITS-1:0] cls;
      logic                last;
   } item_type;

   typedef struct packed {
      logic ansi_quotes;
      logic no_backslash_escapes;
   } cfg_type;

endpackage

FILE: design/sbmc_front.sv
// Front end: takes statement bytes and classifies them into byte classes.
// Depends on sbmc_pkg.
module sbmc_front import sbmc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_byte,
   input  logic       in_last,
   output logic       out_valid,
   input  logic       out_ready,
   output item_type   out_item
);

   localparam logic [7:0] BYTE_NUL    = 8'h00;
   localparam logic [7:0] BYTE_QMARK  = 8'h3F;
   localparam logic [7:0] BYTE_DASH   = 8'h2D;
   localparam logic [7:0] BYTE_SLASH  = 8'h2F;
   localparam logic [7:0] BYTE_STAR   = 8'h2A;
   localparam logic [7:0] BYTE_LF     = 8'h0A;
   localparam logic [7:0] BYTE_SQUOTE = 8'h27;
   localparam logic [7:0] BYTE_DQUOTE = 8'h22;
   localparam logic [7:0] BYTE_BSLASH = 8'h5C;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     take;

   always_comb begin
      case (in_byte)
         BYTE_NUL:    item_in.cls = CLS_ZERO;
         BYTE_QMARK:  item_in.cls = CLS_QMARK;
         BYTE_DASH:   item_in.cls = CLS_DASH;
         BYTE_SLASH:  item_in.cls = CLS_SLASH;
         BYTE_STAR:   item_in.cls = CLS_STAR;
         BYTE_LF:     item_in.cls = CLS_NEWLINE;
         BYTE_SQUOTE: item_in.cls = CLS_SQUOTE;
         BYTE_DQUOTE: item_in.cls = CLS_DQUOTE;
         BYTE_BSLASH: item_in.cls = CLS_BSLASH;
         default:     item_in.cls = CLS_OTHER;
      endcase
      item_in.last = in_last;
   end

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

FILE: design/sbmc_queue.sv
// Short queue of classified bytes between front end and scanner.
// Depends on sbmc_pkg.
module sbmc_queue import sbmc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_valid,
   output logic     wr_ready,
   input  item_type wr_item,
   output logic     rd_valid,
   input  logic     rd_ready,
   output item_type rd_item
);

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   item_type             slot_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 do_wr, do_rd;

   assign wr_ready = (count_ff != CNT_BITS'(QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_valid && rd_ready;
   assign rd_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_wr ? PTR_BITS'((wr_ptr_ff + 1'b1) % QUEUE_DEPTH) : wr_ptr_ff;
      rd_ptr_in = do_rd ? PTR_BITS'((rd_ptr_ff + 1'b1) % QUEUE_DEPTH) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

FILE: design/sbmc_back.sv
// Scanner: runs the comment/string state machine over byte classes,
// counts markers and holds the finished result. Depends on sbmc_pkg.
module sbmc_back import sbmc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  item_type               in_item,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [RESULT_BITS-1:0] out_count,
   output logic                   out_saturated
);

   localparam logic [3:0] M_NORMAL     = 4'd0;
   localparam logic [3:0] M_DASH       = 4'd1;
   localparam logic [3:0] M_SLASH      = 4'd2;
   localparam logic [3:0] M_LINE       = 4'd3;
   localparam logic [3:0] M_BLOCK      = 4'd4;
   localparam logic [3:0] M_BLOCK_STAR = 4'd5;
   localparam logic [3:0] M_SQ         = 4'd6;
   localparam logic [3:0] M_SQ_ESC     = 4'd7;
   localparam logic [3:0] M_SQ_END     = 4'd8;
   localparam logic [3:0] M_DQ         = 4'd9;
   localparam logic [3:0] M_DQ_ESC     = 4'd10;
   localparam logic [3:0] M_DQ_END     = 4'd11;
   localparam logic [3:0] M_STOP       = 4'd12;

   logic [3:0]             mode_ff, mode_in, mode_next;
   logic [COUNT_BITS-1:0]  count_ff, count_in, count_next;
   logic                   sat_ff, sat_in, sat_next;
   logic                   out_valid_ff, out_valid_in;
   logic [RESULT_BITS-1:0] out_count_ff;
   logic                   out_sat_ff;
   logic [3:0]             text_mode;
   logic                   text_hit;
   logic                   hit;
   logic                   take;
   logic                   is_esc;

   // byte seen as plain text
   always_comb begin
      text_hit = 1'b0;
      case (in_item.cls)
         CLS_QMARK: begin
            text_mode = M_NORMAL;
            text_hit  = 1'b1;
         end
         CLS_DASH:   text_mode = M_DASH;
         CLS_SLASH:  text_mode = M_SLASH;
         CLS_SQUOTE: text_mode = M_SQ;
         CLS_DQUOTE: text_mode = cfg.ansi_quotes ? M_NORMAL : M_DQ;
         default:    text_mode = M_NORMAL;
      endcase
   end

   assign is_esc = (in_item.cls == CLS_BSLASH) && !cfg.no_backslash_escapes;

   always_comb begin
      hit       = 1'b0;
      mode_next = mode_ff;
      if (in_item.cls == CLS_ZERO || mode_ff == M_STOP) begin
         mode_next = M_STOP;
      end else begin
         case (mode_ff)
            M_DASH: begin
               if (in_item.cls == CLS_DASH) begin
                  mode_next = M_LINE;
               end else begin
                  mode_next = text_mode;
                  hit       = text_hit;
               end
            end
            M_SLASH: begin
               if (in_item.cls == CLS_STAR) begin
                  mode_next = M_BLOCK;
               end else if (in_item.cls == CLS_SLASH) begin
                  mode_next = M_LINE;
               end else begin
                  mode_next = text_mode;
                  hit       = text_hit;
               end
            end
            M_LINE:  mode_next = (in_item.cls == CLS_NEWLINE) ? M_NORMAL : M_LINE;
            M_BLOCK: mode_next = (in_item.cls == CLS_STAR) ? M_BLOCK_STAR : M_BLOCK;
            M_BLOCK_STAR: begin
               if (in_item.cls == CLS_SLASH) begin
                  mode_next = M_NORMAL;
               end else if (in_item.cls == CLS_STAR) begin
                  mode_next = M_BLOCK_STAR;
               end else begin
                  mode_next = M_BLOCK;
               end
            end
            M_SQ: begin
               if (in_item.cls == CLS_SQUOTE) begin
                  mode_next = M_SQ_END;
               end else if (is_esc) begin
                  mode_next = M_SQ_ESC;
               end else begin
                  mode_next = M_SQ;
               end
            end
            M_SQ_ESC: mode_next = M_SQ;
            M_SQ_END: begin
               // doubled quote stays in the string
               if (in_item.cls == CLS_SQUOTE) begin
                  mode_next = M_SQ;
               end else begin
                  mode_next = text_mode;
                  hit       = text_hit;
               end
            end
            M_DQ: begin
               if (in_item.cls == CLS_DQUOTE) begin
                  mode_next = M_DQ_END;
               end else if (is_esc) begin
                  mode_next = M_DQ_ESC;
               end else begin
                  mode_next = M_DQ;
               end
            end
            M_DQ_ESC: mode_next = M_DQ;
            M_DQ_END: begin
               if (in_item.cls == CLS_DQUOTE) begin
                  mode_next = M_DQ;
               end else begin
                  mode_next = text_mode;
                  hit       = text_hit;
               end
            end
            default: begin
               mode_next = text_mode;
               hit       = text_hit;
            end
         endcase
      end
   end

   always_comb begin
      count_next = count_ff;
      sat_next   = sat_ff;
      if (hit) begin
         if (count_ff == COUNT_MAX) begin
            sat_next = 1'b1;
         end else begin
            count_next = count_ff + COUNT_BITS'(1);
         end
      end
   end

   // a last byte needs the result slot free, or freed this cycle
   assign in_ready = !in_item.last || !out_valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      sat_in   = sat_ff;
      if (take) begin
         if (in_item.last) begin
            mode_in  = M_NORMAL;
            count_in = '0;
            sat_in   = 1'b0;
         end else begin
            mode_in  = mode_next;
            count_in = count_next;
            sat_in   = sat_next;
         end
      end
      out_valid_in = out_valid_ff;
      if (take && in_item.last) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= M_NORMAL;
         count_ff     <= '0;
         sat_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         sat_ff       <= sat_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && in_item.last) begin
         out_count_ff <= RESULT_BITS'(count_next);
         out_sat_ff   <= sat_next;
      end
   end

   assign out_valid     = out_valid_ff;
   assign out_count     = out_count_ff;
   assign out_saturated = out_sat_ff;

endmodule

FILE: design/sql_bind_marker_counter_unit.sv
// SQL bind marker counter: counts '?' markers outside comments and strings.
// Statement bytes go in through a queue-style port; one result per statement
// comes out through a queue-style port.
//   req_stmt_byte/req_last are transferred when push is high and full is low.
//   A zero byte stops scanning; the count is still given at the last byte.
//   rsp_marker_count/rsp_count_saturated hold the oldest result while empty
//   is low; it is transferred when pop is high.
//   csr_wr_en writes csr_wdata into register csr_index (0: ANSI quotes,
//   1: no backslash escapes); write only while no statement is in flight.
// Throughput: one byte per cycle while results are popped; the scanner state
// machine takes one byte each cycle and the counter updates in the same cycle.
// Result path: the last byte passes the front register and the byte queue,
// then its count is loaded into the result register.
// Receiver stall: the result register holds; bytes keep flowing until a
// further last byte reaches the scanner, then the four-entry byte queue and
// the front register fill and full rises.
// Reset: queues empty, scanner in normal text with count zero, both
// configuration registers cleared. No clearing pass.
module sql_bind_marker_counter_unit import sbmc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  logic [7:0]             req_stmt_byte,
   input  logic                   req_last,
   output logic                   empty,
   input  logic                   pop,
   output logic [RESULT_BITS-1:0] rsp_marker_count,
   output logic                   rsp_count_saturated,
   input  logic                   csr_wr_en,
   input  logic                   csr_index,
   input  logic                   csr_wdata
);

   cfg_type  cfg_ff, cfg_in;
   logic     front_ready;
   logic     front_valid;
   item_type front_item;
   logic     queue_ready;
   logic     queue_valid;
   item_type queue_item;
   logic     back_ready;
   logic     rsp_valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_ANSI_QUOTES:   cfg_in.ansi_quotes          = csr_wdata;
            CSR_NO_BS_ESCAPES: cfg_in.no_backslash_escapes = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sbmc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push),
      .in_ready  (front_ready),
      .in_byte   (req_stmt_byte),
      .in_last   (req_last),
      .out_valid (front_valid),
      .out_ready (queue_ready),
      .out_item  (front_item)
   );

   sbmc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (front_valid),
      .wr_ready (queue_ready),
      .wr_item  (front_item),
      .rd_valid (queue_valid),
      .rd_ready (back_ready),
      .rd_item  (queue_item)
   );

   sbmc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .in_valid      (queue_valid),
      .in_ready      (back_ready),
      .in_item       (queue_item),
      .out_valid     (rsp_valid),
      .out_ready     (pop),
      .out_count     (rsp_marker_count),
      .out_saturated (rsp_count_saturated)
   );

   assign full  = !front_ready;
   assign empty = !rsp_valid;

`ifndef SYNTHESIS
   a_reset_clears : assert property (@(posedge clock) reset |=> empty && !full)
      else $error("queues not cleared after reset");

   a_sat_at_max : assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_count_saturated |-> rsp_marker_count == RESULT_BITS'(COUNT_MAX))
      else $error("saturated result without maximum count");

   a_cfg_write : assert property (@(posedge clock) disable iff (reset)
      csr_wr_en && csr_index == CSR_ANSI_QUOTES |=> cfg_ff.ansi_quotes == $past(csr_wdata))
      else $error("configuration write lost");
`endif

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for sql_bind_marker_counter_unit.
// Byte-level scanner prediction, queue-style driver and result checker.
// Depends on sbmc_pkg and the unit under test only.
`timescale 1ns / 100ps

module tb_top;
   import sbmc_pkg::*;

   localparam int STALL_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASE_BYTES = 120;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_DQ     = 8'h22;
   localparam logic [7:0] CH_SQ     = 8'h27;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_QMARK  = 8'h3F;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LOWX   = 8'h78;

   typedef enum logic [3:0] {
      ST_TEXT, ST_DASH, ST_SLASH, ST_LINE, ST_BLOCK, ST_BLOCK_STAR,
      ST_SQ, ST_SQ_ESC, ST_SQ_END, ST_DQ, ST_DQ_ESC, ST_DQ_END, ST_HALT
   } scan_state_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       fin;
   } stmt_item_type;

   typedef struct packed {
      logic [RESULT_BITS-1:0] count;
      logic                   capped;
   } tally_type;

   logic                   clock;
   logic                   reset;
   logic                   push;
   logic                   full;
   logic [7:0]             req_stmt_byte;
   logic                   req_last;
   logic                   empty;
   logic                   pop;
   logic [RESULT_BITS-1:0] rsp_marker_count;
   logic                   rsp_count_saturated;
   logic                   csr_wr_en;
   logic                   csr_index;
   logic                   csr_wdata;

   sql_bind_marker_counter_unit dut (
      .clock(clock), .reset(reset),
      .push(push), .full(full),
      .req_stmt_byte(req_stmt_byte), .req_last(req_last),
      .empty(empty), .pop(pop),
      .rsp_marker_count(rsp_marker_count),
      .rsp_count_saturated(rsp_count_saturated),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   stmt_item_type byte_feed[$];
   tally_type     tally_q[$];

   // scanner copy
   scan_state_type        scan_st;
   logic [COUNT_BITS-1:0] marker_tally;
   logic                  tally_capped;
   logic                  mdl_ansi;
   logic                  mdl_no_esc;

   int  fail_count;
   int  bytes_sent;
   int  results_seen;
   int  capped_seen;
   bit  calm;
   bit  hold_request;
   bit  hold_done;
   bit  taken;
   int  push_idle;
   int  pop_idle;
   int  hold_left;
   tally_type want;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic scan_state_type text_target(input logic [7:0] c);
      if (c == CH_DASH) return ST_DASH;
      if (c == CH_SLASH) return ST_SLASH;
      if (c == CH_SQ) return ST_SQ;
      if (c == CH_DQ && !mdl_ansi) return ST_DQ;
      return ST_TEXT;
   endfunction

   function automatic scan_state_type next_scan(input scan_state_type st,
                                                input logic [7:0] c);
      if (c == CH_NUL || st == ST_HALT) return ST_HALT;
      case (st)
         ST_DASH: return (c == CH_DASH) ? ST_LINE : text_target(c);
         ST_SLASH: begin
            if (c == CH_STAR) return ST_BLOCK;
            if (c == CH_SLASH) return ST_LINE;
            return text_target(c);
         end
         ST_LINE: return (c == CH_NL) ? ST_TEXT : ST_LINE;
         ST_BLOCK: return (c == CH_STAR) ? ST_BLOCK_STAR : ST_BLOCK;
         ST_BLOCK_STAR: begin
            if (c == CH_SLASH) return ST_TEXT;
            return (c == CH_STAR) ? ST_BLOCK_STAR : ST_BLOCK;
         end
         ST_SQ: begin
            if (c == CH_SQ) return ST_SQ_END;
            if (c == CH_BSLASH && !mdl_no_esc) return ST_SQ_ESC;
            return ST_SQ;
         end
         ST_SQ_ESC: return ST_SQ;
         ST_SQ_END: return (c == CH_SQ) ? ST_SQ : text_target(c);
         ST_DQ: begin
            if (c == CH_DQ) return ST_DQ_END;
            if (c == CH_BSLASH && !mdl_no_esc) return ST_DQ_ESC;
            return ST_DQ;
         end
         ST_DQ_ESC: return ST_DQ;
         ST_DQ_END: return (c == CH_DQ) ? ST_DQ : text_target(c);
         default: return text_target(c);
      endcase
   endfunction

   // One accepted byte: count a marker seen in plain text, step the scanner
   // and close the statement on its last byte.
   task automatic advance_scanner(input stmt_item_type item);
      logic in_text;
      in_text = (scan_st == ST_TEXT) || (scan_st == ST_DASH) || (scan_st == ST_SLASH) ||
                (scan_st == ST_SQ_END) || (scan_st == ST_DQ_END);
      if (in_text && item.ch == CH_QMARK) begin
         if (marker_tally == COUNT_MAX) tally_capped = 1'b1;
         else marker_tally = marker_tally + 1'b1;
      end
      scan_st = next_scan(scan_st, item.ch);
      if (item.fin) begin
         tally_q.push_back({marker_tally[RESULT_BITS-1:0], tally_capped});
         scan_st = ST_TEXT;
         marker_tally = '0;
         tally_capped = 1'b0;
      end
   endtask

   task automatic add_text(input string txt, input logic fin);
      int k;
      for (k = 0; k < txt.len(); k++)
         byte_feed.push_back({txt[k], fin && (k == txt.len() - 1)});
   endtask

   task automatic add_random_stmt();
      logic [7:0] text_q[$];
      int  n;
      int  k;
      bit  noise;
      noise = ($urandom_range(0, 9) == 0);
      n = $urandom_range(1, 16);
      for (k = 0; k < n; k++) begin
         if (noise) text_q.push_back(8'($urandom_range(0, 255)));
         else case ($urandom_range(0, 15))
            0, 1, 2: text_q.push_back(CH_QMARK);
            3: text_q.push_back(CH_DASH);
            4: begin text_q.push_back(CH_DASH); text_q.push_back(CH_DASH); end
            5: text_q.push_back(CH_SLASH);
            6: begin text_q.push_back(CH_SLASH); text_q.push_back(CH_SLASH); end
            7: begin text_q.push_back(CH_SLASH); text_q.push_back(CH_STAR); end
            8: begin text_q.push_back(CH_STAR); text_q.push_back(CH_SLASH); end
            9: text_q.push_back(CH_STAR);
            10: text_q.push_back(CH_NL);
            11: text_q.push_back(CH_SQ);
            12: text_q.push_back(CH_DQ);
            13: text_q.push_back(CH_BSLASH);
            14: text_q.push_back(8'($urandom_range(1, 255)));
            default: text_q.push_back(($urandom_range(0, 3) == 0) ? CH_NUL : CH_LOWX);
         endcase
      end
      for (k = 0; k < text_q.size(); k++)
         byte_feed.push_back({text_q[k],
                              (k == text_q.size() - 1) || (noise && $urandom_range(0, 15) == 0)});
   endtask

   task automatic write_csr(input logic idx, input logic value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_ANSI_QUOTES) mdl_ansi = value;
      else mdl_no_esc = value;
   endtask

   // sender holds back until every statement so far has been answered
   task automatic wait_drained();
      while (byte_feed.size() != 0 || tally_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // byte transfer and prediction
   always @(posedge clock) begin
      if (!reset && push && !full) begin
         advance_scanner(byte_feed[0]);
         void'(byte_feed.pop_front());
         bytes_sent++;
         taken = 1'b1;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else if (!(push && !taken)) begin
         taken = 1'b0;
         if (push_idle > 0) begin
            push_idle--;
            push <= 1'b0;
         end else if (byte_feed.size() == 0) begin
            push <= 1'b0;
         end else if (!calm && $urandom_range(0, 11) == 0) begin
            push_idle = $urandom_range(1, 17) - 1;
            push <= 1'b0;
         end else begin
            push <= 1'b1;
            req_stmt_byte <= byte_feed[0].ch;
            req_last <= byte_feed[0].fin;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         pop <= 1'b0;
      end else if (hold_request && !hold_done) begin
         hold_left = HOLD_CYCLES - 1;
         hold_done = 1'b1;
         pop <= 1'b0;
      end else if (pop_idle > 0) begin
         pop_idle--;
         pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
         pop_idle = $urandom_range(1, 17) - 1;
         pop <= 1'b0;
      end else begin
         pop <= 1'b1;
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         results_seen++;
         if (rsp_count_saturated) capped_seen++;
         if (tally_q.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected result: count %0d saturated %0b",
                        rsp_marker_count, rsp_count_saturated);
         end else begin
            want = tally_q.pop_front();
            if (rsp_marker_count !== want.count || rsp_count_saturated !== want.capped) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("mismatch at result %0d: expected count %0d sat %0b, got %0d sat %0b",
                           results_seen, want.count, want.capped,
                           rsp_marker_count, rsp_count_saturated);
            end
         end
      end
   end

   initial begin : watchdog
      int idle_run;
      idle_run = 0;
      while (idle_run < STALL_LIMIT) begin
         @(posedge clock);
         if ((push && !full) || (pop && !empty)) idle_run = 0;
         else idle_run++;
      end
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      int phase;
      int quota;
      reset = 1'b1;
      push = 1'b0;
      pop = 1'b0;
      req_stmt_byte = '0;
      req_last = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = CSR_ANSI_QUOTES;
      csr_wdata = 1'b0;
      scan_st = ST_TEXT;
      marker_tally = '0;
      tally_capped = 1'b0;
      mdl_ansi = 1'b0;
      mdl_no_esc = 1'b0;
      fail_count = 0;
      bytes_sent = 0;
      results_seen = 0;
      capped_seen = 0;
      calm = 1'b0;
      hold_request = 1'b0;
      hold_done = 1'b0;
      taken = 1'b0;
      push_idle = 0;
      pop_idle = 0;
      hold_left = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_csr(CSR_ANSI_QUOTES, 1'b0);
      write_csr(CSR_NO_BS_ESCAPES, 1'b0);
      @(posedge clock);
      add_text("?", 1'b1);
      add_text("-?--?\n?", 1'b1);
      add_text("/*?**/?", 1'b1);
      add_text("'?''?'?", 1'b1);
      add_text("\"\\\"?\"?", 1'b1);
      // stop byte, then a marker that must be ignored
      byte_feed.push_back({8'hFF, 1'b0});
      byte_feed.push_back({CH_NUL, 1'b0});
      byte_feed.push_back({CH_QMARK, 1'b1});
      // backslash on the final byte inside a string
      add_text("'\\", 1'b1);
      wait_drained();

      for (phase = 1; phase <= 8; phase++) begin
         if (phase == 8) calm = 1'b1;
         write_csr(CSR_ANSI_QUOTES, (phase < 8) ? phase[0] : 1'($urandom_range(0, 1)));
         write_csr(CSR_NO_BS_ESCAPES, (phase < 8) ? phase[1] : 1'($urandom_range(0, 1)));
         @(posedge clock);
         if (phase == 3) hold_request = 1'b1;
         quota = byte_feed.size() + PHASE_BYTES;
         while (byte_feed.size() < quota) add_random_stmt();
         wait_drained();
      end

      // statement left open: no result may appear for it
      add_text("?'?-", 1'b0);
      while (byte_feed.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      fail_count += tally_q.size();

      $display("%0d statement bytes sent, %0d results checked (%0d saturated),",
               bytes_sent, results_seen, capped_seen);
      $display("all four quote and escape settings, comments, strings and stop bytes.");
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
